@@ rtl/pmdf_pkg.sv @@
// Package for the power monitor decimating filter.
// Holds field widths, divider sizing, constants and the beat struct types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pmdf_pkg;

    localparam int SMP_W       = 12;
    localparam int PWR_W       = 15;
    localparam int TEXT_W      = 30;
    localparam int SAMPLE_BITS = 12;
    localparam int WINDOW_DEF  = 10;
    localparam int SAMPLE_MAX  = (1 << SMP_W) - 1;
    localparam int POWER_MAX   = 16769;

    localparam int DIV_W = 2 * SMP_W;
    localparam int DVS_W = 10;

    localparam logic [SMP_W-1:0]  SAMPLE_MASK  = SMP_W'((1 << SAMPLE_BITS) - 1);
    localparam logic [DVS_W-1:0]  DVS_TEN      = DVS_W'(10);
    localparam logic [DVS_W-1:0]  DVS_HUNDRED  = DVS_W'(100);
    localparam logic [DVS_W-1:0]  DVS_THOUSAND = DVS_W'(1000);
    localparam logic [DIV_W-1:0]  RCP_TEN      = DIV_W'((1 << DIV_W) / 10);
    localparam logic [DIV_W-1:0]  RCP_HUNDRED  = DIV_W'((1 << DIV_W) / 100);
    localparam logic [DIV_W-1:0]  RCP_THOUSAND = DIV_W'((1 << DIV_W) / 1000);
    localparam logic [TEXT_W-1:0] TEXT_ZERO    = TEXT_W'(32'h3030_3030);

    typedef struct packed {
        logic [SMP_W-1:0] current_sample;
        logic [SMP_W-1:0] voltage_sample;
    } t_in;

    typedef struct packed {
        logic [SMP_W-1:0]  current_filtered;
        logic [SMP_W-1:0]  voltage_filtered;
        logic [PWR_W-1:0]  power_filtered;
        logic [TEXT_W-1:0] current_text;
        logic [TEXT_W-1:0] voltage_text;
    } t_out;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
        logic [DIV_W-1:0] recip;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DVS_W-1:0] rem;
    } t_div_res;

endpackage

`default_nettype wire

@@ rtl/pmdf_divider.sv @@
// Shared divider for constant divisors: reciprocal multiply, back-multiply,
// difference and one correction step on a single multiplier.
// Depends on pmdf_pkg for widths and the request and result structs.
`timescale 1ns / 1ps
`default_nettype none

module pmdf_divider
    import pmdf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_res      o_res
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_EST  = 3'd1;
    localparam logic [2:0] PH_BACK = 3'd2;
    localparam logic [2:0] PH_DIFF = 3'd3;
    localparam logic [2:0] PH_FIX  = 3'd4;

    logic [2:0]       r_phase;
    logic             r_done;
    logic [DIV_W-1:0] r_num;
    logic [DIV_W-1:0] r_recip;
    logic [DVS_W-1:0] r_divisor;
    logic [DIV_W-1:0] r_quot;
    logic [DIV_W-1:0] r_back;
    logic [DIV_W-1:0] r_diff;
    logic [DVS_W-1:0] r_rem;

    logic [DIV_W-1:0]   mul_a;
    logic [DIV_W-1:0]   mul_b;
    logic [2*DIV_W-1:0] mul_p;
    logic [DIV_W-1:0]   over;
    logic               fits;

    always_comb begin
        mul_a = (r_phase == PH_EST) ? r_num   : r_quot;
        mul_b = (r_phase == PH_EST) ? r_recip : DIV_W'(r_divisor);
        mul_p = {{DIV_W{1'b0}}, mul_a} * {{DIV_W{1'b0}}, mul_b};
        over  = r_diff - DIV_W'(r_divisor);
        fits  = r_diff >= DIV_W'(r_divisor);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= r_phase == PH_FIX;
            if (i_req.start) begin
                r_phase <= PH_EST;
            end else begin
                unique case (r_phase)
                    PH_EST:  r_phase <= PH_BACK;
                    PH_BACK: r_phase <= PH_DIFF;
                    PH_DIFF: r_phase <= PH_FIX;
                    default: r_phase <= PH_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num     <= i_req.dividend;
            r_recip   <= i_req.recip;
            r_divisor <= i_req.divisor;
        end
        unique case (r_phase)
            PH_EST:  r_quot <= mul_p[2*DIV_W-1:DIV_W];
            PH_BACK: r_back <= mul_p[DIV_W-1:0];
            PH_DIFF: r_diff <= r_num - r_back;
            PH_FIX: begin
                if (fits) begin
                    r_quot <= r_quot + 1'b1;
                    r_rem  <= over[DVS_W-1:0];
                end else begin
                    r_rem  <= r_diff[DVS_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quot;
    assign o_res.rem  = r_rem;

endmodule

`default_nettype wire

@@ rtl/power_monitor_decimating_filter.sv @@
// Power monitor decimating filter: boxcar windows feeding exponential averages.
// A beat inside a window adds to the sums; the beat that closes a window runs 13
// divisions on the shared divider, one after another.
// One beat is in work at a time; its result beat leaves through an output register.
// Synchronous active-low reset zeroes sums, averages, power; text resets to '0' digits.
// Depends on pmdf_pkg and pmdf_divider.
`timescale 1ns / 1ps
`default_nettype none

module power_monitor_decimating_filter
    import pmdf_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_in  i_data,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_out      o_data
);

    localparam int CSUM_W = $clog2(WINDOW * SAMPLE_MAX + 1);
    localparam int PSUM_W = $clog2(WINDOW * POWER_MAX + 1);
    localparam int POS_W  = $clog2(WINDOW);
    localparam logic [DVS_W-1:0] DVS_WINDOW = DVS_W'(WINDOW);
    localparam logic [DIV_W-1:0] RCP_WINDOW = DIV_W'((1 << DIV_W) / WINDOW);
    localparam logic [7:0]       ASCII_ZERO = 8'h30;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;

    localparam logic [3:0] STEP_CUR_AVG    = 4'd0;
    localparam logic [3:0] STEP_CUR_SMOOTH = 4'd1;
    localparam logic [3:0] STEP_VLT_AVG    = 4'd2;
    localparam logic [3:0] STEP_VLT_SMOOTH = 4'd3;
    localparam logic [3:0] STEP_POWER      = 4'd4;
    localparam logic [3:0] STEP_PWR_AVG    = 4'd5;
    localparam logic [3:0] STEP_PWR_SMOOTH = 4'd6;
    localparam logic [3:0] STEP_CUR_THOU   = 4'd7;
    localparam logic [3:0] STEP_CUR_HUND   = 4'd8;
    localparam logic [3:0] STEP_CUR_TENS   = 4'd9;
    localparam logic [3:0] STEP_VLT_THOU   = 4'd10;
    localparam logic [3:0] STEP_VLT_HUND   = 4'd11;
    localparam logic [3:0] STEP_VLT_TENS   = 4'd12;

    function automatic logic [7:0] to_ascii(input logic [3:0] digit);
        return ASCII_ZERO + {4'd0, digit};
    endfunction

    logic [1:0]        r_state;
    logic [3:0]        r_step;
    logic              r_out_valid;
    logic [CSUM_W-1:0] r_csum;
    logic [CSUM_W-1:0] r_vsum;
    logic [PSUM_W-1:0] r_psum;
    logic [POS_W-1:0]  r_pos;
    logic [SMP_W-1:0]  r_csm;
    logic [SMP_W-1:0]  r_vsm;
    logic [PWR_W-1:0]  r_psm;
    logic [PWR_W-1:0]  r_power;
    logic [PWR_W-1:0]  r_tmp;
    logic [TEXT_W-1:0] r_ctext;
    logic [TEXT_W-1:0] r_vtext;

    logic [SMP_W-1:0]   cur;
    logic [SMP_W-1:0]   volt;
    logic               in_accept;
    logic               out_accept;
    logic               window_end;
    logic [DIV_W-1:0]   product;
    logic [PWR_W-1:0]   old_avg;
    logic [DIV_W-1:0]   blend;
    t_div_req           div_req;
    t_div_res           div_res;

    assign cur        = i_data.current_sample & SAMPLE_MASK;
    assign volt       = i_data.voltage_sample & SAMPLE_MASK;
    assign o_stall    = (r_state != S_IDLE) || (r_out_valid && i_stall);
    assign in_accept  = i_valid && !o_stall;
    assign out_accept = r_out_valid && !i_stall;
    assign window_end = r_pos >= POS_W'(WINDOW - 1);
    assign product    = DIV_W'(r_vsm * r_csm);

    always_comb begin
        unique case (r_step)
            STEP_CUR_SMOOTH: old_avg = PWR_W'(r_csm);
            STEP_VLT_SMOOTH: old_avg = PWR_W'(r_vsm);
            default:         old_avg = r_psm;
        endcase
        blend = (DIV_W'(old_avg) << 3) + DIV_W'(old_avg) + DIV_W'(r_tmp);
    end

    always_comb begin
        div_req.start = r_state == S_ISSUE;
        unique case (r_step)
            STEP_CUR_AVG: begin
                div_req.dividend = DIV_W'(r_csum);
                div_req.divisor  = DVS_WINDOW;
                div_req.recip    = RCP_WINDOW;
            end
            STEP_VLT_AVG: begin
                div_req.dividend = DIV_W'(r_vsum);
                div_req.divisor  = DVS_WINDOW;
                div_req.recip    = RCP_WINDOW;
            end
            STEP_PWR_AVG: begin
                div_req.dividend = DIV_W'(r_psum);
                div_req.divisor  = DVS_WINDOW;
                div_req.recip    = RCP_WINDOW;
            end
            STEP_CUR_SMOOTH, STEP_VLT_SMOOTH, STEP_PWR_SMOOTH: begin
                div_req.dividend = blend;
                div_req.divisor  = DVS_TEN;
                div_req.recip    = RCP_TEN;
            end
            STEP_POWER: begin
                div_req.dividend = product;
                div_req.divisor  = DVS_THOUSAND;
                div_req.recip    = RCP_THOUSAND;
            end
            STEP_CUR_THOU: begin
                div_req.dividend = DIV_W'(r_csm);
                div_req.divisor  = DVS_THOUSAND;
                div_req.recip    = RCP_THOUSAND;
            end
            STEP_VLT_THOU: begin
                div_req.dividend = DIV_W'(r_vsm);
                div_req.divisor  = DVS_THOUSAND;
                div_req.recip    = RCP_THOUSAND;
            end
            STEP_CUR_HUND, STEP_VLT_HUND: begin
                div_req.dividend = DIV_W'(r_tmp);
                div_req.divisor  = DVS_HUNDRED;
                div_req.recip    = RCP_HUNDRED;
            end
            default: begin
                div_req.dividend = DIV_W'(r_tmp);
                div_req.divisor  = DVS_TEN;
                div_req.recip    = RCP_TEN;
            end
        endcase
    end

    pmdf_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_res   (div_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= STEP_CUR_AVG;
            r_out_valid <= 1'b0;
            r_csum      <= '0;
            r_vsum      <= '0;
            r_psum      <= '0;
            r_pos       <= '0;
            r_csm       <= '0;
            r_vsm       <= '0;
            r_psm       <= '0;
            r_power     <= '0;
            r_ctext     <= TEXT_ZERO;
            r_vtext     <= TEXT_ZERO;
        end else begin
            if (out_accept && !(in_accept && !window_end)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_csum <= r_csum + CSUM_W'(cur);
                        r_vsum <= r_vsum + CSUM_W'(volt);
                        if (window_end) begin
                            r_step  <= STEP_CUR_AVG;
                            r_state <= S_ISSUE;
                        end else begin
                            r_psum      <= r_psum + PSUM_W'(r_power);
                            r_pos       <= r_pos + 1'b1;
                            r_out_valid <= 1'b1;
                        end
                    end
                end
                S_ISSUE: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (div_res.done) begin
                        unique case (r_step)
                            STEP_CUR_AVG, STEP_VLT_AVG, STEP_PWR_AVG: begin
                                r_tmp <= div_res.quot[PWR_W-1:0];
                            end
                            STEP_CUR_SMOOTH: r_csm <= div_res.quot[SMP_W-1:0];
                            STEP_VLT_SMOOTH: r_vsm <= div_res.quot[SMP_W-1:0];
                            STEP_PWR_SMOOTH: r_psm <= div_res.quot[PWR_W-1:0];
                            STEP_POWER: begin
                                r_power <= div_res.quot[PWR_W-1:0];
                                r_psum  <= r_psum + PSUM_W'(div_res.quot[PWR_W-1:0]);
                            end
                            STEP_CUR_THOU: begin
                                r_ctext[29:24] <= 6'(to_ascii(div_res.quot[3:0]));
                                r_tmp          <= PWR_W'(div_res.rem);
                            end
                            STEP_CUR_HUND: begin
                                r_ctext[23:16] <= to_ascii(div_res.quot[3:0]);
                                r_tmp          <= PWR_W'(div_res.rem);
                            end
                            STEP_CUR_TENS: begin
                                r_ctext[15:8] <= to_ascii(div_res.quot[3:0]);
                                r_ctext[7:0]  <= to_ascii(div_res.rem[3:0]);
                            end
                            STEP_VLT_THOU: begin
                                r_vtext[29:24] <= 6'(to_ascii(div_res.quot[3:0]));
                                r_tmp          <= PWR_W'(div_res.rem);
                            end
                            STEP_VLT_HUND: begin
                                r_vtext[23:16] <= to_ascii(div_res.quot[3:0]);
                                r_tmp          <= PWR_W'(div_res.rem);
                            end
                            default: begin
                                r_vtext[15:8] <= to_ascii(div_res.quot[3:0]);
                                r_vtext[7:0]  <= to_ascii(div_res.rem[3:0]);
                            end
                        endcase
                        if (r_step == STEP_VLT_TENS) begin
                            r_csum      <= '0;
                            r_vsum      <= '0;
                            r_psum      <= '0;
                            r_pos       <= '0;
                            r_out_valid <= 1'b1;
                            r_state     <= S_IDLE;
                        end else begin
                            r_step  <= r_step + 1'b1;
                            r_state <= S_ISSUE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid                 = r_out_valid;
    assign o_data.current_filtered = r_csm;
    assign o_data.voltage_filtered = r_vsm;
    assign o_data.power_filtered   = r_psm;
    assign o_data.current_text     = r_ctext;
    assign o_data.voltage_text     = r_vtext;

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Testbench for power_monitor_decimating_filter: random and directed sample beats
// checked against a cycle-free model of the windowed averages, power and digit text.
// Depends on pmdf_pkg and the filter RTL.
`timescale 1ns / 1ps
`default_nettype none

module tb;
    import pmdf_pkg::*;

    localparam int WIN           = WINDOW_DEF;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 400;
    localparam int HOLD_CYCLES   = 700;
    localparam int PHASE_BEATS   = 250;

    typedef enum int {
        MODE_UNIFORM,
        MODE_HIGH,
        MODE_LOW,
        MODE_RAIL,
        MODE_STEADY
    } t_mode;

    class filter_scoreboard;
        bit [15:0] cur_sum;
        bit [15:0] volt_sum;
        bit [17:0] pwr_sum;
        bit [3:0]  pos;
        bit [11:0] cur_avg;
        bit [11:0] volt_avg;
        bit [14:0] pwr_avg;
        t_out      filtered_due[$];
        int        errors;

        function new();
            cur_sum  = '0;
            volt_sum = '0;
            pwr_sum  = '0;
            pos      = '0;
            cur_avg  = '0;
            volt_avg = '0;
            pwr_avg  = '0;
            errors   = 0;
        endfunction

        function bit [31:0] ewma(bit [31:0] old, bit [31:0] sum);
            return (old * 9 + sum / WIN) / 10;
        endfunction

        function bit [29:0] ascii_digits(bit [31:0] v);
            bit [31:0] t;
            t = {8'(v / 1000 % 10 + 48), 8'(v / 100 % 10 + 48),
                 8'(v / 10 % 10 + 48), 8'(v % 10 + 48)};
            return t[29:0];
        endfunction

        function void note_sample(t_in beat);
            bit [11:0] cur;
            bit [11:0] volt;
            bit [31:0] pwr;
            bit        closing;
            t_out      r;
            cur     = beat.current_sample & SAMPLE_MASK;
            volt    = beat.voltage_sample & SAMPLE_MASK;
            closing = (pos >= WIN - 1);
            cur_sum  += cur;
            volt_sum += volt;
            if (closing) begin
                cur_avg  = 12'(ewma(cur_avg, cur_sum));
                volt_avg = 12'(ewma(volt_avg, volt_sum));
                cur_sum  = '0;
                volt_sum = '0;
            end
            pwr = (32'(volt_avg) * 32'(cur_avg)) / 1000;
            pwr_sum += 18'(pwr);
            if (closing) begin
                pwr_avg = 15'(ewma(pwr_avg, pwr_sum));
                pwr_sum = '0;
                pos     = '0;
            end else begin
                pos = pos + 1'b1;
            end
            r.current_filtered = cur_avg;
            r.voltage_filtered = volt_avg;
            r.power_filtered   = pwr_avg;
            r.current_text     = ascii_digits(cur_avg);
            r.voltage_text     = ascii_digits(volt_avg);
            filtered_due.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (filtered_due.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
                return;
            end
            want = filtered_due.pop_front();
            compare_field("current_filtered", want.current_filtered, got.current_filtered);
            compare_field("voltage_filtered", want.voltage_filtered, got.voltage_filtered);
            compare_field("power_filtered", want.power_filtered, got.power_filtered);
            compare_field("current_text", want.current_text, got.current_text);
            compare_field("voltage_text", want.voltage_text, got.voltage_text);
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_in  i_data  = '0;
    logic o_stall;
    logic o_valid;
    t_out o_data;

    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    bit          hold_req    = 1'b0;
    int          hold_left   = 0;
    int unsigned cycle_count = 0;

    filter_scoreboard sb = new();

    power_monitor_decimating_filter #(
        .WINDOW(WIN)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result(o_data);
        end
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    task automatic send_sample(input t_in beat);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= beat;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_sample(beat);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.filtered_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_in random_sample(t_mode mode, t_in base);
        t_in s;
        case (mode)
            MODE_HIGH: begin
                s.current_sample = 12'($urandom_range(3800, 4095));
                s.voltage_sample = 12'($urandom_range(3800, 4095));
            end
            MODE_LOW: begin
                s.current_sample = 12'($urandom_range(0, 300));
                s.voltage_sample = 12'($urandom_range(0, 300));
            end
            MODE_RAIL: begin
                s.current_sample = $urandom_range(1) ? 12'hFFF : 12'h000;
                s.voltage_sample = $urandom_range(1) ? 12'hFFF : 12'h000;
            end
            MODE_STEADY: begin
                s.current_sample = base.current_sample ^ 12'($urandom_range(3));
                s.voltage_sample = base.voltage_sample ^ 12'($urandom_range(3));
            end
            default: begin
                s.current_sample = 12'($urandom);
                s.voltage_sample = 12'($urandom);
            end
        endcase
        return s;
    endfunction

    task automatic run_random(input int count);
        int    left;
        int    seg;
        int    pick;
        t_mode mode;
        t_in   base;
        left = count;
        while (left > 0) begin
            seg  = $urandom_range(8, 40);
            pick = $urandom_range(9);
            if (pick < 3) mode = MODE_UNIFORM;
            else if (pick < 6) mode = MODE_HIGH;
            else if (pick == 6) mode = MODE_LOW;
            else if (pick == 7) mode = MODE_RAIL;
            else mode = MODE_STEADY;
            base = t_in'($urandom);
            for (int k = 0; k < seg && left > 0; k++) begin
                send_sample(random_sample(mode, base));
                left--;
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_sample({12'h000, 12'h000});
        send_sample({12'hFFF, 12'hFFF});
        send_sample({12'hFFF, 12'h000});
        send_sample({12'h000, 12'hFFF});
        send_sample({12'hAAA, 12'h555});
        send_sample({12'h555, 12'hAAA});
        repeat (14) send_sample({12'hFFF, 12'hFFF});
        drain();

        tx_idle_pct = 26;
        rx_idle_pct = 77;
        run_random(PHASE_BEATS);
        drain();

        tx_idle_pct = 77;
        rx_idle_pct = 26;
        run_random(PHASE_BEATS);
        drain();

        // hold the output side off while beats keep coming
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req    = 1'b1;
        run_random(PHASE_BEATS);
        drain();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ power_monitor_decimating_filter.f @@
rtl/pmdf_pkg.sv
rtl/pmdf_divider.sv
rtl/power_monitor_decimating_filter.sv
bench/tb.sv
